@@ hdl/rrb_pkg.sv @@
// Shared types, constants and codes for the reliable retransmit tracker.
// No dependencies; imported by the backoff unit, the top level and the checker.
package rrb_pkg;

	localparam int MAX_FRAME_BYTES_D = 512;
	localparam int MAX_SENDS_D       = 5;
	localparam int DEFAULT_BASE_MS_D = 300;

	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int WORD_W      = 64;
	localparam int LEN_W       = 10;
	localparam int WP_W        = 7;
	localparam int BASE_W      = 22;
	localparam int ATT_W       = 4;
	localparam int TIME_W      = 32;
	localparam int CTR_W       = 32;
	localparam int FLEN_W      = 16;

	localparam logic [WP_W-1:0] WP_MAX = {WP_W{1'b1}};

	// input modes
	localparam logic [1:0] MODE_SEND = 2'd0;
	localparam logic [1:0] MODE_ACK  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// result status codes
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_RETX    = 3'd1;
	localparam logic [2:0] ST_TIMEOUT = 3'd2;
	localparam logic [2:0] ST_ACCEPT  = 3'd3;
	localparam logic [2:0] ST_REJECT  = 3'd4;
	localparam logic [2:0] ST_ACK_HIT = 3'd5;
	localparam logic [2:0] ST_ACK_MISS = 3'd6;

	// backoff scaling: 11/10 margin, then 8/5 per attempt past threshold plus one
	localparam int MARGIN_NUM        = 11;
	localparam int BACKOFF_THRESHOLD = 1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic             start;
		logic [ATT_W-1:0] attempt;
	} bo_req_t;

	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] interval;
	} bo_rsp_t;

endpackage

@@ hdl/rrb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; width and depth come in as parameters.
module rrb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/rrb_backoff.sv @@
// Retry interval unit: base*11/10, then *8/5 per attempt past the second.
// Divides by 10 or 5 one byte per cycle; uses rrb_pkg.
module rrb_backoff import rrb_pkg::*; #(
	parameter int DEFAULT_BASE_MS = DEFAULT_BASE_MS_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BASE_W-1:0] base,
	input  bo_req_t           req,
	output bo_rsp_t           rsp
);

	localparam int DVD_W = 40;
	localparam int NBYTES = DVD_W / 8;
	localparam logic [BASE_W-1:0] DEF_BASE = BASE_W'(DEFAULT_BASE_MS);
	// reciprocals scaled by 2^16; exact for a remainder digit pair below 256*divisor
	localparam logic [12:0] RECIP10 = 13'd6554;
	localparam logic [13:0] RECIP5  = 14'd13108;
	localparam logic [ATT_W-1:0] FIRST_GROWTH = ATT_W'(1 + BACKOFF_THRESHOLD);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [3:0]        rem_q;
	logic [2:0]        cnt_q;
	logic              by10_q;
	logic [ATT_W-1:0]  steps_q;
	logic              busy_q;
	logic              done_q;
	logic [TIME_W-1:0] interval_q;

	logic [BASE_W-1:0] base_eff;
	logic [25:0]       base_scaled;
	logic [11:0]       v;
	logic [24:0]       prod10;
	logic [25:0]       prod5;
	logic [7:0]        qd;
	logic [11:0]       qd_times;
	logic [11:0]       rem_full;
	logic [DVD_W-1:0]  quo_next;
	logic [TIME_W-1:0] t_next;

	always_comb begin
		base_eff    = (base != '0) ? base : DEF_BASE;
		base_scaled = 26'(base_eff) * 26'(MARGIN_NUM);
		v           = {rem_q, dvd_q[DVD_W-1 -: 8]};
		prod10      = 25'(v) * 25'(RECIP10);
		prod5       = 26'(v) * 26'(RECIP5);
		qd          = by10_q ? prod10[23:16] : prod5[23:16];
		qd_times    = by10_q ? (12'(qd) * 12'd10) : (12'(qd) * 12'd5);
		rem_full    = v - qd_times;
		quo_next    = {quo_q[DVD_W-9:0], qd};
		t_next      = quo_next[TIME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
			steps_q    <= '0;
			by10_q     <= 1'b0;
			rem_q      <= '0;
			interval_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				rem_q   <= '0;
				by10_q  <= 1'b1;
				steps_q <= (req.attempt > FIRST_GROWTH) ? (req.attempt - FIRST_GROWTH) : '0;
			end else if (busy_q) begin
				rem_q <= rem_full[3:0];
				if (cnt_q == 3'(NBYTES - 1)) begin
					cnt_q <= '0;
					rem_q <= '0;
					if (steps_q == '0) begin
						interval_q <= t_next;
						done_q     <= 1'b1;
						busy_q     <= 1'b0;
					end else begin
						steps_q <= steps_q - 1'b1;
						by10_q  <= 1'b0;
					end
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	// dividend and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= DVD_W'(base_scaled);
			quo_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'(NBYTES - 1)) begin
				dvd_q <= {5'b0, t_next, 3'b0};
				quo_q <= '0;
			end else begin
				dvd_q <= {dvd_q[DVD_W-9:0], 8'h00};
				quo_q <= quo_next;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.interval = interval_q;

endmodule

@@ hdl/reliable_retransmit_backoff.sv @@
// A send word passes the execute state; a last word or an ack then puts a result in the
// output register, and an accepted reliable frame first gets its deadline from the backoff
// divider. A due tick replays the frame from the RAM, one word per cycle while the output
// is not stalled, then runs the divider. One item at a time; the next is taken when the
// sequencer is idle. Reset clears tracking state and the write pointer, not the frame RAM.
module reliable_retransmit_backoff import rrb_pkg::*; #(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_D,
	parameter int MAX_SENDS       = MAX_SENDS_D,
	parameter int DEFAULT_BASE_MS = DEFAULT_BASE_MS_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [BASE_W-1:0] base_interval_ms,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [WORD_W-1:0] data_word,
	input  logic [FLEN_W-1:0] frame_len,
	input  logic [CTR_W-1:0]  msg_counter,
	input  logic              reliable,
	input  logic              last,
	input  logic [CTR_W-1:0]  ack_counter,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [FLEN_W-1:0] out_capacity,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [WORD_W-1:0] frame_word,
	output logic [LEN_W-1:0]  frame_length_out,
	output logic              last_word
);

	localparam logic [FLEN_W-1:0] MAX_LEN    = FLEN_W'(MAX_FRAME_BYTES);
	localparam logic [ATT_W-1:0]  MAX_TRIES  = ATT_W'(MAX_SENDS);
	localparam logic [WP_W-1:0]   DEPTH_WP   = WP_W'(STORE_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RESP = 3'd2;
	localparam logic [2:0] S_BOFF = 3'd3;
	localparam logic [2:0] S_READ = 3'd4;
	localparam logic [2:0] S_XFER = 3'd5;

	logic [2:0]          state_q;

	// captured item
	logic [1:0]          mode_q;
	logic [WORD_W-1:0]   data_q;
	logic [FLEN_W-1:0]   flen_q;
	logic [CTR_W-1:0]    mctr_q;
	logic                rel_q;
	logic                last_q;
	logic [CTR_W-1:0]    actr_q;
	logic [TIME_W-1:0]   now_q;
	logic [FLEN_W-1:0]   cap_q;

	// tracking state
	logic [BASE_W-1:0]   base_q;
	logic [LEN_W-1:0]    stored_q;
	logic                pending_q;
	logic [ATT_W-1:0]    attempt_q;
	logic [CTR_W-1:0]    tracked_q;
	logic [TIME_W-1:0]   next_due_q;
	logic [WP_W-1:0]     wp_q;

	logic [2:0]          resp_status_q;
	logic                resp_after_q;
	logic [STORE_AW-1:0] k_q;
	logic [WP_W-1:0]     nwords_q;

	// output register
	logic                out_valid_q;
	logic [2:0]          status_q;
	logic [WORD_W-1:0]   frame_word_q;
	logic [LEN_W-1:0]    frame_length_q;
	logic                last_word_q;

	logic                in_accept;
	logic                out_free;
	logic                ld_resp;
	logic                ld_retx;
	logic                fits;
	logic [WP_W-1:0]     wp_new;
	logic [13:0]         need_words;
	logic                frame_ok;
	logic [TIME_W-1:0]   due_diff;
	logic                tick_due;
	logic                tick_timeout;
	logic                ack_hit;
	logic                exec_track;
	logic                fin;
	logic [7:0]          nw_full;
	logic [WORD_W-1:0]   tail_mask;

	logic                ram_we;
	logic                ram_re;
	logic [STORE_AW-1:0] ram_raddr;
	word_t               ram_rdata;

	bo_req_t             bo_req;
	bo_rsp_t             bo_rsp;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		ld_resp    = (state_q == S_RESP) && out_free;
		ld_retx    = (state_q == S_XFER) && out_free;

		fits       = (flen_q != '0) && (flen_q <= MAX_LEN);
		wp_new     = (wp_q < WP_MAX) ? (wp_q + 1'b1) : wp_q;
		need_words = 14'((17'(flen_q) + 17'd7) >> 3);
		frame_ok   = fits && (14'(wp_new) >= need_words);
		exec_track = (mode_q == MODE_SEND) && last_q && rel_q && frame_ok;

		due_diff     = now_q - next_due_q;
		tick_due     = pending_q && !due_diff[TIME_W-1];
		tick_timeout = (attempt_q >= MAX_TRIES) || (FLEN_W'(stored_q) > cap_q);
		ack_hit      = pending_q && (actr_q == tracked_q);

		nw_full   = 8'((11'(stored_q) + 11'd7) >> 3);
		fin       = ({1'b0, k_q} + 7'd1) == nwords_q;
		// final word keeps only the bytes inside the frame
		tail_mask = (stored_q[2:0] == 3'd0) ? {WORD_W{1'b1}}
			: ~({WORD_W{1'b1}} << {stored_q[2:0], 3'b000});

		ram_we    = (state_q == S_EXEC) && (mode_q == MODE_SEND) && rel_q && fits
			&& (wp_q < DEPTH_WP);
		ram_re    = (state_q == S_READ) || (ld_retx && !fin);
		ram_raddr = (state_q == S_READ) ? '0 : (k_q + 1'b1);

		bo_req.start   = ((state_q == S_EXEC) && exec_track) || (ld_retx && fin);
		bo_req.attempt = (state_q == S_EXEC) ? ATT_W'(1) : (attempt_q + 1'b1);
	end

	rrb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q[STORE_AW-1:0]),
		.wdata (data_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rrb_backoff #(
		.DEFAULT_BASE_MS(DEFAULT_BASE_MS)
	) u_backoff (
		.clk    (clk),
		.arst_n (arst_n),
		.base   (base_q),
		.req    (bo_req),
		.rsp    (bo_rsp)
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q <= mode;
			data_q <= data_word;
			flen_q <= frame_len;
			mctr_q <= msg_counter;
			rel_q  <= reliable;
			last_q <= last;
			actr_q <= ack_counter;
			now_q  <= now_ms;
			cap_q  <= out_capacity;
		end
		if (ld_resp) begin
			status_q       <= resp_status_q;
			frame_word_q   <= '0;
			frame_length_q <= '0;
			last_word_q    <= 1'b1;
		end else if (ld_retx) begin
			status_q       <= ST_RETX;
			frame_word_q   <= fin ? (ram_rdata & tail_mask) : ram_rdata;
			frame_length_q <= stored_q;
			last_word_q    <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			base_q        <= '0;
			stored_q      <= '0;
			pending_q     <= 1'b0;
			attempt_q     <= '0;
			tracked_q     <= '0;
			next_due_q    <= '0;
			wp_q          <= '0;
			resp_status_q <= ST_IDLE;
			resp_after_q  <= 1'b0;
			k_q           <= '0;
			nwords_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= base_interval_ms;
			end

			if (ld_resp || ld_retx) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (mode_q)
						MODE_SEND: begin
							if (rel_q && fits) begin
								wp_q      <= wp_new;
								pending_q <= 1'b0;
							end
							if (last_q) begin
								wp_q <= '0;
								if (!rel_q) begin
									resp_status_q <= ST_ACCEPT;
									state_q       <= S_RESP;
								end else if (frame_ok) begin
									stored_q      <= flen_q[LEN_W-1:0];
									tracked_q     <= mctr_q;
									attempt_q     <= ATT_W'(1);
									pending_q     <= 1'b1;
									resp_status_q <= ST_ACCEPT;
									resp_after_q  <= 1'b1;
									state_q       <= S_BOFF;
								end else begin
									resp_status_q <= ST_REJECT;
									state_q       <= S_RESP;
								end
							end else begin
								state_q <= S_IDLE;
							end
						end
						MODE_ACK: begin
							if (ack_hit) begin
								pending_q     <= 1'b0;
								resp_status_q <= ST_ACK_HIT;
							end else begin
								resp_status_q <= ST_ACK_MISS;
							end
							state_q <= S_RESP;
						end
						MODE_TICK: begin
							if (!tick_due) begin
								resp_status_q <= ST_IDLE;
								state_q       <= S_RESP;
							end else if (tick_timeout) begin
								pending_q     <= 1'b0;
								resp_status_q <= ST_TIMEOUT;
								state_q       <= S_RESP;
							end else begin
								nwords_q <= (nw_full > 8'(STORE_DEPTH)) ? DEPTH_WP
									: nw_full[WP_W-1:0];
								state_q  <= S_READ;
							end
						end
						default: begin
							resp_status_q <= ST_IDLE;
							state_q       <= S_RESP;
						end
					endcase
				end
				S_READ: begin
					k_q     <= '0;
					state_q <= S_XFER;
				end
				S_XFER: begin
					if (ld_retx) begin
						if (fin) begin
							attempt_q    <= attempt_q + 1'b1;
							resp_after_q <= 1'b0;
							state_q      <= S_BOFF;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_BOFF: begin
					if (bo_rsp.done) begin
						next_due_q <= now_q + bo_rsp.interval;
						state_q    <= resp_after_q ? S_RESP : S_IDLE;
					end
				end
				S_RESP: begin
					if (ld_resp) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign frame_word       = frame_word_q;
	assign frame_length_out = frame_length_q;
	assign last_word        = last_word_q;

endmodule

@@ hdl/rrb_checker.sv @@
// Port-level checks for the retransmit tracker, bound to the top level.
// Uses rrb_pkg status codes; sees only the top level's ports.
module rrb_checker import rrb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [BASE_W-1:0] base_interval_ms,
	input logic              in_valid,
	input logic              in_stall,
	input logic [1:0]        mode,
	input logic [WORD_W-1:0] data_word,
	input logic [FLEN_W-1:0] frame_len,
	input logic [CTR_W-1:0]  msg_counter,
	input logic              reliable,
	input logic              last,
	input logic [CTR_W-1:0]  ack_counter,
	input logic [TIME_W-1:0] now_ms,
	input logic [FLEN_W-1:0] out_capacity,
	input logic              out_valid,
	input logic              out_stall,
	input logic [2:0]        status,
	input logic [WORD_W-1:0] frame_word,
	input logic [LEN_W-1:0]  frame_length_out,
	input logic              last_word
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_word)
			&& $stable(frame_length_out) && $stable(last_word))
		else $error("result changed while stalled");

	// one item at a time: after a transfer in, the input side stalls
	a_in_serial: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous item in flight");

	a_retx_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RETX |-> frame_length_out != '0)
		else $error("retransmit word without frame length");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_RETX |-> frame_word == '0 && frame_length_out == '0
			&& last_word)
		else $error("non-retransmit result carries payload");

endmodule

bind reliable_retransmit_backoff rrb_checker u_rrb_checker (.*);
